// ===== rtl/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

    localparam int MAX_RESULTS  = 3;
    localparam int RES_DEPTH    = 8;
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
    localparam int RES_CNT_BITS = RES_PTR_BITS + 1;
    localparam logic [RES_CNT_BITS-1:0] RES_ROOM_LIMIT = RES_CNT_BITS'(RES_DEPTH - MAX_RESULTS);

    localparam int OUT_COUNT_BITS = 24;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [7:0] LOWER_OFFSET = 8'd26;
    localparam logic [7:0] DIGIT_OFFSET = 8'd52;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_INVALID   = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0]                data_byte;
        logic                      is_status;
        logic [1:0]                status;
        logic [OUT_COUNT_BITS-1:0] total_count;
        logic                      last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                   num;
        out_item_t [MAX_RESULTS-1:0] item;
    } push_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } lookup_t;

    function automatic lookup_t sextet_lookup(input logic [7:0] c);
        lookup_t r;
        r.ok    = 1'b1;
        r.value = 6'd0;
        if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
        begin
            r.value = 6'(c - CHAR_UPPER_A);
        end
        else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
        begin
            r.value = 6'(c - CHAR_LOWER_A + LOWER_OFFSET);
        end
        else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]})
        begin
            r.value = 6'(c - CHAR_DIGIT_0 + DIGIT_OFFSET);
        end
        else if (c == CHAR_PLUS)
        begin
            r.value = SEXTET_PLUS;
        end
        else if (c == CHAR_SLASH)
        begin
            r.value = SEXTET_SLASH;
        end
        else if (c != CHAR_PAD)
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// Streaming base64 decoder, one text character per transaction.
// Input channel char_*: char_item carries char_code and end_of_text; a
// transaction completes on a clock edge with char_valid high and char_stall low.
// Output channel res_*: each res_item is either a decoded data byte or, for an
// end-of-text transaction, one status item with the running byte count.
// Every result of a transaction carries last on its final item.
// Throughput: one character per cycle while char_stall is low. A character
// is decoded in the cycle it is taken; its 0 to 3 results are registered into
// an 8-entry result queue and offered in order, one per cycle, on res_* while
// res_stall is low. char_stall rises when fewer than three queue entries are
// free; this only happens while the receiver holds res_stall high. A stalled
// result stays on res_item unchanged until taken.
// Reset clears the group state, the error flag, the byte count and the
// queue; res_valid is low and char_stall is low after reset.
// After an end-of-text transaction all state outside the queue returns to
// its reset values. The byte count is COUNT_BITS wide and saturates;
// total_count shows its low 24 bits.
`default_nettype none

module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      char_valid,
    output logic           char_stall,
    input  wire in_item_t  char_item,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_item_t      res_item
);

    localparam int WIDE_BITS = COUNT_BITS + OUT_COUNT_BITS;

    logic [1:0]            group_position_reg, group_position_next;
    logic [5:0]            held_sextets_reg [3];
    logic [5:0]            held_sextets_next [3];
    logic                  third_was_pad_reg, third_was_pad_next;
    logic                  decoding_finished_reg, decoding_finished_next;
    logic                  error_reg, error_next;
    logic [COUNT_BITS-1:0] byte_count_reg, byte_count_next;

    logic                  room;
    logic                  accept;
    logic                  is_pad;
    lookup_t               look;
    push_t                 push;
    logic [1:0]            num;
    logic [7:0]            bytes [MAX_RESULTS];
    logic [COUNT_BITS:0]   sums [MAX_RESULTS];
    logic [COUNT_BITS-1:0] counts [MAX_RESULTS];
    logic [WIDE_BITS-1:0]  wide_counts [MAX_RESULTS];
    logic [WIDE_BITS-1:0]  wide_now;

    assign char_stall = !room;
    assign accept     = char_valid && !char_stall;
    assign is_pad     = (char_item.char_code == CHAR_PAD);
    assign look       = sextet_lookup(char_item.char_code);
    assign wide_now   = {{OUT_COUNT_BITS{1'b0}}, byte_count_reg};

    always_comb
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            sums[k]        = {1'b0, byte_count_reg} + (COUNT_BITS + 1)'(k + 1);
            counts[k]      = sums[k][COUNT_BITS] ? '1 : sums[k][COUNT_BITS-1:0];
            wide_counts[k] = {{OUT_COUNT_BITS{1'b0}}, counts[k]};
        end
        bytes[0] = {held_sextets_reg[0], held_sextets_reg[1][5:4]};
        bytes[1] = {held_sextets_reg[1][3:0], held_sextets_reg[2][5:2]};
        bytes[2] = {held_sextets_reg[2][1:0], look.value};
        if (third_was_pad_reg)
        begin
            num = 2'd1;
        end
        else if (is_pad)
        begin
            num = 2'd2;
        end
        else
        begin
            num = 2'd3;
        end
    end

    always_comb
    begin
        group_position_next    = group_position_reg;
        held_sextets_next      = held_sextets_reg;
        third_was_pad_next     = third_was_pad_reg;
        decoding_finished_next = decoding_finished_reg;
        error_next             = error_reg;
        byte_count_next        = byte_count_reg;
        push                   = '0;

        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            push.item[2'(k)].data_byte   = bytes[k];
            push.item[2'(k)].is_status   = 1'b0;
            push.item[2'(k)].status      = STATUS_OK;
            push.item[2'(k)].total_count = wide_counts[k][OUT_COUNT_BITS-1:0];
            push.item[2'(k)].last        = (2'(k + 1) == num);
        end

        if (accept)
        begin
            if (char_item.end_of_text)
            begin
                push.num                  = 2'd1;
                push.item[0].data_byte    = 8'd0;
                push.item[0].is_status    = 1'b1;
                push.item[0].total_count  = wide_now[OUT_COUNT_BITS-1:0];
                push.item[0].last         = 1'b1;
                if (error_reg)
                begin
                    push.item[0].status = STATUS_INVALID;
                end
                else if (group_position_reg != 2'd0 && !decoding_finished_reg)
                begin
                    push.item[0].status = STATUS_TRUNCATED;
                end
                else
                begin
                    push.item[0].status = STATUS_OK;
                end
                group_position_next    = 2'd0;
                held_sextets_next      = '{3{6'd0}};
                third_was_pad_next     = 1'b0;
                decoding_finished_next = 1'b0;
                error_next             = 1'b0;
                byte_count_next        = '0;
            end
            else if (char_item.char_code == CHAR_CR || char_item.char_code == CHAR_LF)
            begin
                // skip line breaks
            end
            else if (decoding_finished_reg || error_reg)
            begin
                // drop until end of text
            end
            else if (!look.ok)
            begin
                error_next = 1'b1;
            end
            else if (group_position_reg != 2'd3)
            begin
                held_sextets_next[group_position_reg] = look.value;
                if (group_position_reg == 2'd2)
                begin
                    third_was_pad_next = is_pad;
                end
                group_position_next = group_position_reg + 2'd1;
            end
            else
            begin
                push.num            = num;
                byte_count_next     = counts[num - 2'd1];
                group_position_next = 2'd0;
                third_was_pad_next  = 1'b0;
                if (num != 2'd3)
                begin
                    decoding_finished_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_position_reg    <= 2'd0;
            held_sextets_reg      <= '{3{6'd0}};
            third_was_pad_reg     <= 1'b0;
            decoding_finished_reg <= 1'b0;
            error_reg             <= 1'b0;
            byte_count_reg        <= '0;
        end
        else
        begin
            group_position_reg    <= group_position_next;
            held_sextets_reg      <= held_sextets_next;
            third_was_pad_reg     <= third_was_pad_next;
            decoding_finished_reg <= decoding_finished_next;
            error_reg             <= error_next;
            byte_count_reg        <= byte_count_next;
        end
    end

    b64d_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.is_status |-> res_item.last)
        else $error("status item without last");

    a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.is_status |-> res_item.status == STATUS_OK)
        else $error("data item with nonzero status");

    a_finished_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        !(decoding_finished_reg && error_reg))
        else $error("finished and error both set");

    a_finished_group_empty: assert property (@(posedge clk) disable iff (!rst_n)
        decoding_finished_reg |-> group_position_reg == 2'd0 && !third_was_pad_reg)
        else $error("group state left after padded group");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && char_item.end_of_text |=> group_position_reg == 2'd0
            && byte_count_reg == '0 && !error_reg && !decoding_finished_reg)
        else $error("state not cleared after end of text");

endmodule

`default_nettype wire

// ===== rtl/b64d_result_queue.sv =====
`default_nettype none

module b64d_result_queue
    import b64d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire push_t     push,
    output logic           room,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_item_t      res_item
);

    out_item_t                mem [RES_DEPTH];
    logic [RES_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_BITS-1:0]  count_reg, count_next;
    logic                     pop;

    assign room      = (count_reg <= RES_ROOM_LIMIT);
    assign res_valid = (count_reg != '0);
    assign res_item  = mem[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_BITS'(push.num);
        rd_ptr_next = rd_ptr_reg + RES_PTR_BITS'(pop);
        count_next  = count_reg + RES_CNT_BITS'(push.num) - RES_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < push.num)
            begin
                mem[wr_ptr_reg + RES_PTR_BITS'(k)] <= push.item[2'(k)];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/decode_checker.sv =====
`timescale 1ns / 1ps

module decode_checker
    import b64d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      char_valid,
    input  wire logic      char_stall,
    input  wire in_item_t  char_item,
    input  wire logic      res_valid,
    input  wire logic      res_stall,
    input  wire out_item_t res_item,
    output int             fail_count,
    output int             pending_count
);

    localparam int COUNT_WIDTH = 24;

    bit [1:0]             group_pos;
    bit [5:0]             held [3];
    bit                   third_pad;
    bit                   text_done;
    bit                   invalid_seen;
    bit [COUNT_WIDTH-1:0] decoded_total;
    out_item_t            expected_bytes [$];
    out_item_t            oldest;

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic bit to_sextet(input logic [7:0] c, output logic [5:0] v);
        v = 6'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            v = 6'(c - CHAR_UPPER_A);
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            v = 6'(c - CHAR_LOWER_A + LOWER_OFFSET);
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            v = 6'(c - CHAR_DIGIT_0 + DIGIT_OFFSET);
        else if (c == CHAR_PLUS)
            v = SEXTET_PLUS;
        else if (c == CHAR_SLASH)
            v = SEXTET_SLASH;
        else if (c != CHAR_PAD)
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_text_state();
        group_pos     = 2'd0;
        held[0]       = 6'd0;
        held[1]       = 6'd0;
        held[2]       = 6'd0;
        third_pad     = 1'b0;
        text_done     = 1'b0;
        invalid_seen  = 1'b0;
        decoded_total = '0;
    endtask

    task automatic decode_char(input in_item_t it);
        out_item_t  r;
        logic [5:0] v;
        logic [7:0] bytes [3];
        int         n;
        r = '0;
        if (it.end_of_text)
        begin
            r.is_status = 1'b1;
            if (invalid_seen)
                r.status = STATUS_INVALID;
            else if (group_pos != 2'd0 && !text_done)
                r.status = STATUS_TRUNCATED;
            else
                r.status = STATUS_OK;
            r.total_count = decoded_total[OUT_COUNT_BITS-1:0];
            r.last        = 1'b1;
            expected_bytes.push_back(r);
            clear_text_state();
        end
        else if (it.char_code == CHAR_CR || it.char_code == CHAR_LF || text_done || invalid_seen)
        begin
        end
        else if (!to_sextet(it.char_code, v))
            invalid_seen = 1'b1;
        else if (group_pos != 2'd3)
        begin
            held[group_pos] = v;
            if (group_pos == 2'd2)
                third_pad = (it.char_code == CHAR_PAD);
            group_pos++;
        end
        else
        begin
            bytes[0] = {held[0], held[1][5:4]};
            bytes[1] = {held[1][3:0], held[2][5:2]};
            bytes[2] = {held[2][1:0], v};
            n = third_pad ? 1 : (it.char_code == CHAR_PAD) ? 2 : 3;
            for (int k = 0; k < n; k++)
            begin
                if (decoded_total != '1)
                    decoded_total++;
                r             = '0;
                r.data_byte   = bytes[k];
                r.total_count = decoded_total[OUT_COUNT_BITS-1:0];
                r.last        = (k == n - 1);
                expected_bytes.push_back(r);
            end
            group_pos = 2'd0;
            third_pad = 1'b0;
            if (n < 3)
                text_done = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && !char_stall)
                decode_char(char_item);
            if (res_valid && !res_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("result with nothing expected: 0x%0h", res_item);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_bytes.pop_front();
                    check_field("data_byte", oldest.data_byte, res_item.data_byte);
                    check_field("is_status", oldest.is_status, res_item.is_status);
                    check_field("status", oldest.status, res_item.status);
                    check_field("total_count", oldest.total_count, res_item.total_count);
                    check_field("last", oldest.last, res_item.last);
                end
            end
            pending_count = expected_bytes.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import b64d_pkg::*;

    localparam int HOLD_CYCLES = 150;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      char_valid;
    logic      char_stall;
    in_item_t  char_item;
    logic      res_valid;
    logic      res_stall;
    out_item_t res_item;
    int        fail_count;
    int        pending_count;

    int        send_idle_pct = 13;
    int        recv_idle_pct = 13;
    bit        hold_req      = 1'b0;
    bit        hold_done     = 1'b0;
    int        chars_sent    = 0;

    base64_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

    decode_checker check_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_item     (char_item),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res_item      (res_item),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                res_stall <= 1'b1;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(negedge clk);
            end
            else
                res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26)
            return CHAR_UPPER_A + 8'(v);
        if (v < 6'd52)
            return CHAR_LOWER_A + 8'(v - 6'd26);
        if (v < SEXTET_PLUS)
            return CHAR_DIGIT_0 + 8'(v - 6'd52);
        return (v == SEXTET_PLUS) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= it;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        if (!it.end_of_text && it.char_code != CHAR_CR && it.char_code != CHAR_LF)
            chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [7:0] c);
        in_item_t it;
        it.char_code   = c;
        it.end_of_text = 1'b0;
        send_item(it);
    endtask

    task automatic send_eot();
        in_item_t it;
        it.char_code   = 8'($urandom_range(0, 255));
        it.end_of_text = 1'b1;
        send_item(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_alpha(input int break_pct);
        if ($urandom_range(0, 99) < break_pct)
            send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        send_char(sextet_char(6'($urandom_range(0, 63))));
    endtask

    // pad: 0 none, 1 two-pad tail, 2 one-pad tail
    task automatic send_groups(input int groups, input int pad, input int break_pct);
        for (int g = 0; g < groups * 4; g++)
            send_alpha(break_pct);
        if (pad == 1)
        begin
            send_alpha(break_pct);
            send_alpha(break_pct);
            send_char(CHAR_PAD);
            send_char(CHAR_PAD);
        end
        else if (pad == 2)
        begin
            send_alpha(break_pct);
            send_alpha(break_pct);
            send_alpha(break_pct);
            send_char(CHAR_PAD);
        end
    endtask

    task automatic send_random_text();
        int kind;
        int pad_at;
        kind = $urandom_range(0, 99);
        if (kind < 70)
            send_groups($urandom_range(0, 4), $urandom_range(0, 2), 10);
        else if (kind < 78)
        begin
            send_groups($urandom_range(0, 2), 0, 10);
            repeat ($urandom_range(1, 3)) send_alpha(10);
        end
        else if (kind < 86)
        begin
            send_groups($urandom_range(0, 2), $urandom_range(1, 2), 10);
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
        end
        else if (kind < 94)
        begin
            send_groups($urandom_range(0, 2), 0, 10);
            repeat ($urandom_range(0, 3)) send_alpha(10);
            send_char(8'($urandom_range(0, 255)));
            repeat (2) send_alpha(10);
        end
        else
        begin
            pad_at = $urandom_range(0, 1);
            for (int i = 0; i < 4; i++)
            begin
                if (i == pad_at)
                    send_char(CHAR_PAD);
                else
                    send_alpha(10);
            end
            send_groups($urandom_range(0, 1), $urandom_range(0, 2), 10);
        end
        send_eot();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_item  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("TW");
        send_char(CHAR_CR);
        send_text("Fu");
        send_eot();
        send_text("/+9zTQ==");
        send_char(8'hFF);
        send_eot();
        send_text("TWE=");
        send_eot();
        send_char(8'h00);
        send_eot();
        send_text("==A");
        send_eot();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (chars_sent < 60)
            send_random_text();

        hold_req = 1'b1;
        send_groups(12, 0, 0);
        send_eot();

        char_valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 13;
        while (chars_sent < 200)
            send_random_text();

        char_valid <= 1'b0;
        wait (pending_count == 0);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
